[sv/ct_pkg.sv]
// ----------------------------------------------------------------------------
// ct_pkg
// Shared types and constants for the charstring tokeniser.
// ----------------------------------------------------------------------------
package ct_pkg;

  typedef enum logic [2:0] {
    KIND_OP    = 3'd0,
    KIND_ESC   = 3'd1,
    KIND_INT   = 3'd2,
    KIND_FIXED = 3'd3,
    KIND_TRUNC = 3'd4
  } token_kind_t;

  localparam logic [7:0] LEAD_ESCAPE    = 8'd12;
  localparam logic [7:0] LEAD_SHORTINT  = 8'd28;
  localparam logic [7:0] LEAD_FIXED     = 8'd255;
  localparam logic [7:0] OP_LIMIT       = 8'd32;
  localparam logic [7:0] INT1_MAX       = 8'd246;
  localparam logic [7:0] INT2_POS_BASE  = 8'd247;
  localparam logic [7:0] INT2_NEG_BASE  = 8'd251;
  localparam logic [7:0] INT1_BIAS      = 8'd139;
  localparam logic [7:0] INT2_BIAS      = 8'd108;
  localparam logic [7:0] FLEX_FIRST     = 8'd34;
  localparam logic [7:0] FLEX_LAST      = 8'd37;

  // reserved one-byte operators 0, 2, 9, 11, 13, 14 and 17
  localparam logic [31:0] RESERVED_OP_MASK = 32'h0002_6A05;

  localparam logic [2:0] NEED_ONE   = 3'd1;
  localparam logic [2:0] NEED_TWO   = 3'd2;
  localparam logic [2:0] NEED_FOUR  = 3'd4;

  typedef struct packed {
    logic [2:0]  bytes_pending;
    logic [7:0]  lead_byte;
    logic [31:0] gathered_bytes;
    logic        string_is_short;
  } state_t;

  typedef struct packed {
    token_kind_t        token_kind;
    logic [7:0]         op_code;
    logic               is_reserved;
    logic signed [31:0] number_value;
    logic               token_last;
  } token_t;

endpackage

[sv/ct_byte_if.sv]
// ----------------------------------------------------------------------------
// ct_byte_if
// Byte channel into the tokeniser: one charstring byte with its marks.
// ----------------------------------------------------------------------------
interface ct_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_of_string;
  logic       last_of_string;

  modport source (output valid, output data_byte, output first_of_string,
                  output last_of_string, input ready);
  modport sink   (input valid, input data_byte, input first_of_string,
                  input last_of_string, output ready);
endinterface

[sv/ct_token_if.sv]
// ----------------------------------------------------------------------------
// ct_token_if
// Token channel out of the tokeniser.
// ----------------------------------------------------------------------------
interface ct_token_if;
  logic               valid;
  logic               ready;
  logic [2:0]         token_kind;
  logic [7:0]         op_code;
  logic               is_reserved;
  logic signed [31:0] number_value;
  logic               token_last;

  modport source (output valid, output token_kind, output op_code,
                  output is_reserved, output number_value, output token_last,
                  input ready);
  modport sink   (input valid, input token_kind, input op_code,
                  input is_reserved, input number_value, input token_last,
                  output ready);
endinterface

[sv/ct_decode.sv]
// ----------------------------------------------------------------------------
// ct_decode
// One tokeniser step: current state and byte in, next state and token out.
// ----------------------------------------------------------------------------
module ct_decode (
  input  ct_pkg::state_t state,
  input  logic [7:0]     data_byte,
  input  logic           first_of_string,
  input  logic           last_of_string,
  output ct_pkg::state_t state_next,
  output logic           emit,
  output ct_pkg::token_t token
);

  ct_pkg::state_t     st;
  logic [31:0]        gathered;
  logic [2:0]         pending;
  logic [1:0]         off_pos;
  logic [1:0]         off_neg;
  logic [10:0]        mag2;
  logic signed [31:0] int1_val;

  assign off_pos  = 2'(st.lead_byte - ct_pkg::INT2_POS_BASE);
  assign off_neg  = 2'(st.lead_byte - ct_pkg::INT2_NEG_BASE);
  assign gathered = {st.gathered_bytes[23:0], data_byte};
  assign pending  = 3'(st.bytes_pending - 3'd1);
  assign int1_val = 32'(signed'({1'b0, data_byte})) - 32'(signed'({1'b0, ct_pkg::INT1_BIAS}));

  always_comb begin
    st = state;
    if (first_of_string) begin
      st.bytes_pending  = '0;
      st.lead_byte      = '0;
      st.gathered_bytes = '0;
    end
    mag2 = '0;
    state_next = st;
    emit = 1'b0;
    token.token_kind   = ct_pkg::KIND_OP;
    token.op_code      = data_byte;
    token.is_reserved  = 1'b0;
    token.number_value = '0;
    token.token_last   = last_of_string;

    if (first_of_string && last_of_string) begin
      state_next.string_is_short = 1'b1;
    end else begin
      state_next.string_is_short = 1'b0;
      if (st.bytes_pending == 3'd0) begin
        if (data_byte < ct_pkg::OP_LIMIT && data_byte != ct_pkg::LEAD_ESCAPE &&
            data_byte != ct_pkg::LEAD_SHORTINT) begin
          emit = 1'b1;
          token.is_reserved = ct_pkg::RESERVED_OP_MASK[data_byte[4:0]];
        end else if (data_byte >= ct_pkg::OP_LIMIT && data_byte <= ct_pkg::INT1_MAX) begin
          emit = 1'b1;
          token.token_kind   = ct_pkg::KIND_INT;
          token.number_value = int1_val;
        end else begin
          state_next.lead_byte      = data_byte;
          state_next.gathered_bytes = '0;
          if (last_of_string) begin
            emit = 1'b1;
            token.token_kind = ct_pkg::KIND_TRUNC;
            state_next.bytes_pending = '0;
          end else if (data_byte == ct_pkg::LEAD_SHORTINT) begin
            state_next.bytes_pending = ct_pkg::NEED_TWO;
          end else if (data_byte == ct_pkg::LEAD_FIXED) begin
            state_next.bytes_pending = ct_pkg::NEED_FOUR;
          end else begin
            state_next.bytes_pending = ct_pkg::NEED_ONE;
          end
        end
      end else begin
        state_next.gathered_bytes = gathered;
        state_next.bytes_pending  = pending;
        token.op_code = st.lead_byte;
        if (pending != 3'd0) begin
          if (last_of_string) begin
            emit = 1'b1;
            token.token_kind = ct_pkg::KIND_TRUNC;
            state_next.bytes_pending = '0;
          end
        end else begin
          emit = 1'b1;
          if (st.lead_byte == ct_pkg::LEAD_ESCAPE) begin
            token.token_kind  = ct_pkg::KIND_ESC;
            token.op_code     = data_byte;
            token.is_reserved = !(data_byte >= ct_pkg::FLEX_FIRST &&
                                  data_byte <= ct_pkg::FLEX_LAST);
          end else if (st.lead_byte == ct_pkg::LEAD_SHORTINT) begin
            token.token_kind   = ct_pkg::KIND_INT;
            token.number_value = 32'(signed'(gathered[15:0]));
          end else if (st.lead_byte >= ct_pkg::INT2_POS_BASE &&
                       st.lead_byte < ct_pkg::INT2_NEG_BASE) begin
            mag2 = {1'b0, off_pos, data_byte} + 11'(ct_pkg::INT2_BIAS);
            token.token_kind   = ct_pkg::KIND_INT;
            token.number_value = 32'(signed'({1'b0, mag2}));
          end else if (st.lead_byte >= ct_pkg::INT2_NEG_BASE &&
                       st.lead_byte != ct_pkg::LEAD_FIXED) begin
            mag2 = {1'b0, off_neg, data_byte} + 11'(ct_pkg::INT2_BIAS);
            token.token_kind   = ct_pkg::KIND_INT;
            token.number_value = -32'(signed'({1'b0, mag2}));
          end else begin
            token.token_kind   = ct_pkg::KIND_FIXED;
            token.number_value = signed'(gathered);
          end
        end
      end
    end
  end

endmodule

[sv/charstring_tokenizer.sv]
// ----------------------------------------------------------------------------
// charstring_tokenizer
// Splits a charstring byte stream into operator and number tokens.
// ----------------------------------------------------------------------------
// Output: a token is registered and appears on the output in the cycle after
//   the beat of the byte that completes it.
// Throughput: one byte per cycle while the output register is free, set by the state update loop.
// Reset: synchronous; clears the tokeniser state and the output valid.
// ----------------------------------------------------------------------------
module charstring_tokenizer (
  input logic        clk,
  input logic        rst,
  ct_byte_if.sink    bytes,
  ct_token_if.source tokens
);

  ct_pkg::state_t state;
  ct_pkg::state_t state_next;
  ct_pkg::token_t token_next;
  ct_pkg::token_t token_q;
  logic           emit;
  logic           out_valid;
  logic           accept;
  logic           out_free;

  assign out_free     = !out_valid || tokens.ready;
  assign bytes.ready  = out_free;
  assign accept       = bytes.valid && out_free;

  ct_decode u_decode (
    .state           (state),
    .data_byte       (bytes.data_byte),
    .first_of_string (bytes.first_of_string),
    .last_of_string  (bytes.last_of_string),
    .state_next      (state_next),
    .emit            (emit),
    .token           (token_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        state <= state_next;
      end
      if (out_free) begin
        out_valid <= accept && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      token_q <= token_next;
    end
  end

  assign tokens.valid        = out_valid;
  assign tokens.token_kind   = token_q.token_kind;
  assign tokens.op_code      = token_q.op_code;
  assign tokens.is_reserved  = token_q.is_reserved;
  assign tokens.number_value = token_q.number_value;
  assign tokens.token_last   = token_q.token_last;

  a_short_drops : assert property (@(posedge clk) disable iff (rst)
    accept && bytes.first_of_string && bytes.last_of_string |=> !tokens.valid)
    else $error("one-byte charstring produced a token");

  a_last_emits : assert property (@(posedge clk) disable iff (rst)
    accept && bytes.last_of_string && !bytes.first_of_string
      |=> tokens.valid && tokens.token_last)
    else $error("closing byte did not produce a final token");

  a_last_closes : assert property (@(posedge clk) disable iff (rst)
    accept && bytes.last_of_string |=> state.bytes_pending == 3'd0)
    else $error("token left open after closing byte");

  a_trunc_clean : assert property (@(posedge clk) disable iff (rst)
    tokens.valid && tokens.token_kind == ct_pkg::KIND_TRUNC
      |-> tokens.number_value == 32'sd0 && tokens.token_last)
    else $error("malformed truncated token");

endmodule

[tb/sv/ct_token_check.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ct_token_check
// Watches both tokeniser channels, works out the token that each accepted
// byte completes and compares every token beat against the oldest one due.
// ----------------------------------------------------------------------------
module ct_token_check (
  input  logic clk,
  input  logic rst,
  ct_byte_if   bytes,
  ct_token_if  tokens,
  output int   errors,
  output int   outstanding
);

  logic [2:0]     bytes_pending;
  logic [7:0]     lead_byte;
  logic [31:0]    gathered;
  ct_pkg::token_t tokens_due[$];

  function automatic bit tokenize_byte(input logic [7:0] b, input logic first,
                                       input logic last, output ct_pkg::token_t tok);
    tok = '0;
    tok.token_last = last;
    if (first) begin
      bytes_pending = '0;
      lead_byte = '0;
      gathered = '0;
    end
    if (first && last) return 1'b0;

    if (bytes_pending == '0) begin
      tok.op_code = b;
      if (b < ct_pkg::OP_LIMIT && b != ct_pkg::LEAD_ESCAPE && b != ct_pkg::LEAD_SHORTINT) begin
        tok.token_kind = ct_pkg::KIND_OP;
        tok.is_reserved = ct_pkg::RESERVED_OP_MASK[b[4:0]];
        return 1'b1;
      end
      if (b >= ct_pkg::OP_LIMIT && b <= ct_pkg::INT1_MAX) begin
        tok.token_kind = ct_pkg::KIND_INT;
        tok.number_value = int'(b) - int'(ct_pkg::INT1_BIAS);
        return 1'b1;
      end
      lead_byte = b;
      gathered = '0;
      if (last) begin
        tok.token_kind = ct_pkg::KIND_TRUNC;
        return 1'b1;
      end
      case (b)
        ct_pkg::LEAD_SHORTINT: bytes_pending = ct_pkg::NEED_TWO;
        ct_pkg::LEAD_FIXED:    bytes_pending = ct_pkg::NEED_FOUR;
        default:               bytes_pending = ct_pkg::NEED_ONE;
      endcase
      return 1'b0;
    end

    gathered = {gathered[23:0], b};
    bytes_pending = bytes_pending - 3'd1;
    tok.op_code = lead_byte;
    if (bytes_pending != '0) begin
      if (!last) return 1'b0;
      tok.token_kind = ct_pkg::KIND_TRUNC;
      bytes_pending = '0;
      return 1'b1;
    end

    if (lead_byte == ct_pkg::LEAD_ESCAPE) begin
      tok.token_kind = ct_pkg::KIND_ESC;
      tok.op_code = b;
      tok.is_reserved = !(b >= ct_pkg::FLEX_FIRST && b <= ct_pkg::FLEX_LAST);
    end else if (lead_byte == ct_pkg::LEAD_SHORTINT) begin
      tok.token_kind = ct_pkg::KIND_INT;
      tok.number_value = {{16{gathered[15]}}, gathered[15:0]};
    end else if (lead_byte < ct_pkg::INT2_NEG_BASE) begin
      tok.token_kind = ct_pkg::KIND_INT;
      tok.number_value = (int'(lead_byte) - int'(ct_pkg::INT2_POS_BASE)) * 256 + int'(b)
                         + int'(ct_pkg::INT2_BIAS);
    end else if (lead_byte != ct_pkg::LEAD_FIXED) begin
      tok.token_kind = ct_pkg::KIND_INT;
      tok.number_value = -(int'(lead_byte) - int'(ct_pkg::INT2_NEG_BASE)) * 256 - int'(b)
                         - int'(ct_pkg::INT2_BIAS);
    end else begin
      tok.token_kind = ct_pkg::KIND_FIXED;
      tok.number_value = gathered;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    ct_pkg::token_t due_tok;
    ct_pkg::token_t new_tok;
    if (rst) begin
      bytes_pending = '0;
      lead_byte = '0;
      gathered = '0;
      tokens_due.delete();
      errors = 0;
    end else begin
      if (tokens.valid && tokens.ready) begin
        if (tokens_due.size() == 0) begin
          $display("%0t: unexpected token: kind %0d op %0d rsv %0b value %0d last %0b",
                   $time, tokens.token_kind, tokens.op_code, tokens.is_reserved,
                   tokens.number_value, tokens.token_last);
          errors++;
        end else begin
          due_tok = tokens_due.pop_front();
          if (tokens.token_kind !== due_tok.token_kind ||
              tokens.op_code !== due_tok.op_code ||
              tokens.is_reserved !== due_tok.is_reserved ||
              tokens.number_value !== due_tok.number_value ||
              tokens.token_last !== due_tok.token_last) begin
            $display("%0t: token mismatch: expected kind %0d op %0d rsv %0b value %0d last %0b",
                     $time, due_tok.token_kind, due_tok.op_code, due_tok.is_reserved,
                     due_tok.number_value, due_tok.token_last);
            $display("%0t:                 actual   kind %0d op %0d rsv %0b value %0d last %0b",
                     $time, tokens.token_kind, tokens.op_code, tokens.is_reserved,
                     tokens.number_value, tokens.token_last);
            errors++;
          end
        end
      end
      if (bytes.valid && bytes.ready) begin
        if (tokenize_byte(bytes.data_byte, bytes.first_of_string, bytes.last_of_string,
                          new_tok))
          tokens_due.push_back(new_tok);
      end
    end
    outstanding = tokens_due.size();
  end

endmodule

[tb/sv/charstring_tokenizer_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// charstring_tokenizer_tb
// Feeds the tokeniser directed and random charstrings with random gaps and
// output stalls; the token checker beside the block judges every beat.
// ----------------------------------------------------------------------------
module charstring_tokenizer_tb;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int TARGET_BYTES   = 650;
  localparam int HOLDOFF_CYCLES = 150;

  logic clk;
  logic rst;
  int   errors;
  int   outstanding;
  int   cycles = 0;
  int   bytes_sent = 0;
  bit   tx_burst = 1'b0;
  bit   rx_burst = 1'b0;
  bit   holdoff_req = 1'b0;
  logic [7:0] frame[$];

  ct_byte_if  bytes();
  ct_token_if tokens();

  charstring_tokenizer uut (
    .clk    (clk),
    .rst    (rst),
    .bytes  (bytes),
    .tokens (tokens)
  );

  ct_token_check chk (
    .clk         (clk),
    .rst         (rst),
    .bytes       (bytes),
    .tokens      (tokens),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int pick_gap(bit burst);
    int r;
    r = int'($urandom_range(0, 99));
    if (burst || r < 60) return 0;
    if (r < 93) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
    int gap;
    gap = pick_gap(tx_burst);
    if (gap > 0) begin
      @(negedge clk);
      bytes.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    bytes.valid           <= 1'b1;
    bytes.data_byte       <= b;
    bytes.first_of_string <= first;
    bytes.last_of_string  <= last;
    do @(posedge clk); while (bytes.ready !== 1'b1);
    bytes_sent++;
  endtask

  task automatic drop_valid();
    @(negedge clk);
    bytes.valid <= 1'b0;
  endtask

  task automatic send_frame(input bit mark_first, input bit mark_last, input int len);
    for (int i = 0; i < len; i++)
      send_byte(frame[i], mark_first && i == 0, mark_last && i == len - 1);
    frame.delete();
  endtask

  function automatic void push_token();
    logic [7:0] op;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        op = 8'($urandom_range(0, 31));
        if (op == ct_pkg::LEAD_ESCAPE || op == ct_pkg::LEAD_SHORTINT) op = op + 8'd1;
        frame.push_back(op);
      end
      3: begin
        frame.push_back(ct_pkg::LEAD_ESCAPE);
        if ($urandom_range(0, 1))
          frame.push_back(8'($urandom_range(ct_pkg::FLEX_FIRST, ct_pkg::FLEX_LAST)));
        else frame.push_back(8'($urandom_range(0, 255)));
      end
      4, 5: frame.push_back(8'($urandom_range(ct_pkg::OP_LIMIT, ct_pkg::INT1_MAX)));
      6, 7: begin
        frame.push_back(8'($urandom_range(ct_pkg::INT2_POS_BASE, ct_pkg::LEAD_FIXED - 8'd1)));
        frame.push_back(8'($urandom_range(0, 255)));
      end
      8: begin
        frame.push_back(ct_pkg::LEAD_SHORTINT);
        repeat (2) frame.push_back(8'($urandom_range(0, 255)));
      end
      default: begin
        frame.push_back(ct_pkg::LEAD_FIXED);
        repeat (4) frame.push_back(8'($urandom_range(0, 255)));
      end
    endcase
  endfunction

  // output side: random stalls, burst stretches and one long hold-off
  initial begin
    int stall;
    int holdoff_left;
    bit hold_taken;
    stall = 0;
    holdoff_left = 0;
    hold_taken = 1'b0;
    tokens.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (holdoff_req && !hold_taken) begin
        holdoff_left = HOLDOFF_CYCLES;
        hold_taken = 1'b1;
      end
      if (holdoff_left > 0) begin
        tokens.ready <= 1'b0;
        holdoff_left--;
      end else if (stall > 0) begin
        tokens.ready <= 1'b0;
        stall--;
      end else begin
        if ($urandom_range(0, 149) == 0) rx_burst = !rx_burst;
        stall = pick_gap(rx_burst);
        tokens.ready <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  initial begin
    int r;
    int n_tok;
    bit held;
    bit paused;
    held = 1'b0;
    paused = 1'b0;
    rst = 1'b1;
    bytes.valid = 1'b0;
    bytes.data_byte = '0;
    bytes.first_of_string = 1'b0;
    bytes.last_of_string = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: every token form, some at their extremes, then the odd cases
    frame = '{8'h00, 8'h1F, ct_pkg::OP_LIMIT, ct_pkg::INT1_MAX, ct_pkg::INT2_POS_BASE,
              8'h00, 8'hFE, 8'hFF, ct_pkg::LEAD_SHORTINT, 8'h80, 8'h00,
              ct_pkg::LEAD_ESCAPE, ct_pkg::FLEX_FIRST, ct_pkg::LEAD_ESCAPE, 8'h00,
              ct_pkg::LEAD_FIXED, 8'h80, 8'h00, 8'h00, 8'h01};
    send_frame(1'b1, 1'b1, frame.size());
    frame = '{8'h11};
    send_frame(1'b1, 1'b1, 1);
    frame = '{ct_pkg::LEAD_SHORTINT, 8'h05};
    send_frame(1'b1, 1'b0, 2);
    frame = '{ct_pkg::LEAD_FIXED, ct_pkg::LEAD_ESCAPE};
    send_frame(1'b1, 1'b1, 2);
    frame = '{8'h0E, ct_pkg::INT2_NEG_BASE};
    send_frame(1'b1, 1'b1, 2);

    while (bytes_sent < TARGET_BYTES) begin
      if (!held && bytes_sent >= 200) begin
        holdoff_req = 1'b1;
        held = 1'b1;
      end
      if (!paused && bytes_sent >= 420) begin
        drop_valid();
        wait (outstanding == 0);
        paused = 1'b1;
      end
      tx_burst = ($urandom_range(0, 3) == 0);
      n_tok = int'($urandom_range(1, 10));
      repeat (n_tok) push_token();
      r = int'($urandom_range(0, 99));
      if (r < 70) begin
        send_frame(1'b1, 1'b1, frame.size());
      end else if (r < 80) begin
        frame.delete();
        frame.push_back(8'($urandom_range(0, 255)));
        send_frame(1'b1, 1'b1, 1);
      end else if (r < 90) begin
        send_frame(1'b1, 1'b1, int'($urandom_range(1, frame.size())));
      end else if (r < 95) begin
        send_frame(1'b1, 1'b0, int'($urandom_range(1, frame.size())));
      end else begin
        frame.delete();
        repeat ($urandom_range(1, 6))
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0,
                    $urandom_range(0, 4) == 0);
      end
    end

    drop_valid();
    wait (outstanding == 0);
    repeat (20) @(posedge clk);
    if (errors == 0 && outstanding == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
